[hdl/r2fft_pkg.sv]
// Package: shared types and constants for the radix-2 FFT engine
`timescale 1ns / 1ps
`default_nettype none
package r2fft_pkg;
  localparam int BIN_BITS = 21;
  localparam int TW_BITS = 18;
  localparam int TW_FRAC = 15;
  localparam logic [0:0] REG_INVERSE_MODE = 1'b0;

  // Twiddle W(k) = cos(k*step) - j*sin(k*step), step = 2*pi/n, Q3.15, rounded
  typedef struct packed {
    logic signed [TW_BITS-1:0] re;
    logic signed [TW_BITS-1:0] im;
  } tw_t;

  function automatic tw_t tw_lookup(input int k, input real step);
    tw_t t;
    real ph;
    ph = step * real'(k);
    t.re = TW_BITS'($rtoi($floor($cos(ph) * 32768.0 + 0.5)));
    t.im = TW_BITS'(-$rtoi($floor($sin(ph) * 32768.0 + 0.5)));
    return t;
  endfunction
endpackage
`default_nettype wire

[hdl/r2fft_bfly.sv]
// Butterfly: rounded twiddle product, sum and difference, registered
`timescale 1ns / 1ps
`default_nettype none
module r2fft_bfly #(
  parameter int DW = 21
) (
  input  wire                      clk,
  input  wire                      en,
  input  wire signed [DW-1:0]      er,
  input  wire signed [DW-1:0]      ei,
  input  wire signed [DW-1:0]      odr,
  input  wire signed [DW-1:0]      odi,
  input  wire r2fft_pkg::tw_t      tw,
  output logic signed [DW-1:0]     ar,
  output logic signed [DW-1:0]     ai,
  output logic signed [DW-1:0]     br,
  output logic signed [DW-1:0]     bi
);
  localparam int PW = DW + r2fft_pkg::TW_BITS + 1;
  logic signed [PW-1:0] pr, pi;
  logic signed [DW-1:0] tr, ti;

  always_comb begin
    pr = PW'(odr * tw.re) - PW'(odi * tw.im) + PW'(1 <<< (r2fft_pkg::TW_FRAC - 1));
    pi = PW'(odr * tw.im) + PW'(odi * tw.re) + PW'(1 <<< (r2fft_pkg::TW_FRAC - 1));
    tr = DW'(pr >>> r2fft_pkg::TW_FRAC);
    ti = DW'(pi >>> r2fft_pkg::TW_FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar <= er + tr;
      ai <= ei + ti;
      br <= er - tr;
      bi <= ei - ti;
    end
  end
endmodule
`default_nettype wire

[hdl/radix2_fft_engine.sv]
// Top level: radix-2 DIT FFT engine with sample buffer, butterfly unit and APB port
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  sample   | in_valid/in_ready   | sample_real, sample_imag
//  bin      | out_valid/out_ready | bin_real, bin_imag, bin_number, last_bin
//  config   | APB psel/penable    | inverse_mode at address 0
//
// Load takes one sample per cycle; a transform takes POINTS/2*log2(POINTS)
// butterflies, each made of two reads, one compute and two writes, then
// the output reads of all POINTS bins.
// in_ready stays low from the last sample until the last bin transfers; a
// stalled bin holds. inverse_mode is taken when the last sample lands.
// Reset clears the load count and the sequencer; the buffer keeps no reset.
`timescale 1ns / 1ps
`default_nettype none
module radix2_fft_engine #(
  parameter int POINTS = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire signed [SAMPLE_BITS-1:0] sample_real,
  input  wire signed [SAMPLE_BITS-1:0] sample_imag,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [20:0]      bin_real,
  output logic signed [20:0]      bin_imag,
  output logic [3:0]              bin_number,
  output logic                    last_bin,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire [2:0]               paddr,
  input  wire [31:0]              pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  localparam int LG = $clog2(POINTS);
  localparam int AW = (LG < 1) ? 1 : LG;
  localparam int SW = (LG < 1) ? 1 : $clog2(LG + 1);
  localparam int DW = SAMPLE_BITS + LG + 2;
  localparam int OW = r2fft_pkg::BIN_BITS;
  localparam real TW_STEP = 6.283185307179586 / POINTS;
  localparam logic [2:0] ST_LOAD = 3'd0, ST_RD0 = 3'd1, ST_RD1 = 3'd2, ST_CALC = 3'd3,
                         ST_WR0 = 3'd4, ST_WR1 = 3'd5, ST_OUT = 3'd6;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } cpx_t;

  cpx_t mem [POINTS];
  cpx_t rdata, rdx, even_q;

  logic [2:0] state, state_next;
  logic [AW-1:0] load_count;
  logic [SW-1:0] stage;
  logic [AW-1:0] bidx;
  logic [AW:0] oidx;
  logic inverse_mode, inv;
  logic rd_pend;
  logic [AW-1:0] rd_num;
  logic hold_valid;
  logic [AW-1:0] hold_num;

  function automatic logic [AW-1:0] brev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) r[AW-1-b] = v[b];
    return r;
  endfunction

  // Butterfly addresses for stage s (half = 2^s), butterfly index j
  logic [AW-1:0] half_m, kk, ea, oa, twk;
  always_comb begin
    half_m = AW'((1 << stage) - 1);
    kk = bidx & half_m;
    ea = AW'({bidx, 1'b0} - {1'b0, kk});
    oa = AW'(ea + half_m + 1'b1);
    twk = AW'(kk << (LG - 1 - stage));
  end

  r2fft_pkg::tw_t twv;
  always_comb begin
    twv = '0;
    for (int t = 0; t < POINTS / 2; t++)
      if (twk == AW'(t)) twv = r2fft_pkg::tw_lookup(t, TW_STEP);
  end

  // Conjugate samples on their first-stage reads in inverse mode
  always_comb begin
    rdx = rdata;
    if (inv && stage == '0 && state != ST_OUT) rdx.im = -rdata.im;
  end

  logic signed [DW-1:0] ar, ai, br, bi;
  r2fft_bfly #(.DW(DW)) u_bfly (
    .clk(clk), .en(state == ST_CALC), .er(even_q.re), .ei(even_q.im),
    .odr(rdx.re), .odi(rdx.im),
    .tw(twv), .ar(ar), .ai(ai), .br(br), .bi(bi)
  );

  logic out_take;
  assign out_take = !hold_valid || out_ready;
  assign in_ready = (state == ST_LOAD);
  assign pready = 1'b1;
  assign prdata = {31'd0, inverse_mode};

  logic last_b;
  assign last_b = (bidx == AW'(POINTS / 2 - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_valid && load_count == AW'(POINTS - 1)) state_next = ST_RD0;
      ST_RD0:  state_next = ST_RD1;
      ST_RD1:  state_next = ST_CALC;
      ST_CALC: state_next = ST_WR0;
      ST_WR0:  state_next = ST_WR1;
      ST_WR1:  state_next = (last_b && stage == SW'(LG - 1)) ? ST_OUT : ST_RD0;
      ST_OUT:  if (oidx == (AW+1)'(POINTS) && !rd_pend && out_take) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // Buffer: one write port and one read port, read data registered
  logic we;
  logic [AW-1:0] waddr, raddr;
  cpx_t wdata;
  logic rd_issue;
  assign rd_issue = (state == ST_OUT) && oidx != (AW+1)'(POINTS) && (!rd_pend || out_take)
                    && out_take;
  always_comb begin
    we = 1'b0;
    waddr = brev(load_count);
    wdata.re = DW'(sample_real);
    wdata.im = DW'(sample_imag);
    raddr = ea;
    unique case (state)
      ST_LOAD: we = in_valid;
      ST_WR0: begin we = 1'b1; waddr = ea; wdata.re = ar; wdata.im = ai; end
      ST_WR1: begin we = 1'b1; waddr = oa; wdata.re = br; wdata.im = bi; end
      ST_RD1: raddr = oa;
      ST_OUT: raddr = rd_issue ? oidx[AW-1:0] : rd_num;
      default: raddr = ea;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
    if (state == ST_RD1) even_q <= rdx;
  end

  logic signed [DW-1:0] fr, fi;
  always_comb begin
    fr = rdata.re;
    fi = rdata.im;
    if (inv) begin
      fr = DW'((rdata.re + DW'(POINTS / 2)) >>> LG);
      fi = DW'((-rdata.im + DW'(POINTS / 2)) >>> LG);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      load_count <= '0;
      stage <= '0;
      bidx <= '0;
      oidx <= '0;
      inverse_mode <= 1'b0;
      inv <= 1'b0;
      rd_pend <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr[2] == r2fft_pkg::REG_INVERSE_MODE)
        inverse_mode <= pwdata[0];
      if (state == ST_LOAD && in_valid) begin
        load_count <= AW'(load_count + 1'b1);
        if (load_count == AW'(POINTS - 1)) inv <= inverse_mode;
      end
      if (state == ST_WR1) begin
        bidx <= last_b ? '0 : AW'(bidx + 1'b1);
        if (last_b) stage <= SW'(stage + 1'b1);
      end
      if (state == ST_LOAD) begin
        stage <= '0;
        oidx <= '0;
      end
      if (out_take) hold_valid <= rd_pend;
      if (rd_issue) begin
        rd_pend <= 1'b1;
        rd_num <= oidx[AW-1:0];
        oidx <= oidx + 1'b1;
      end else if (out_take) begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend && out_take) begin
      bin_real <= OW'(fr);
      bin_imag <= OW'(fi);
      hold_num <= rd_num;
    end
  end

  assign out_valid = hold_valid;
  assign bin_number = 4'(hold_num);
  assign last_bin = (hold_num == AW'(POINTS - 1));
endmodule
`default_nettype wire
